/* rtl/core/ste_pkg.sv */
// Shared types, field widths and codes for the submatrix transpose engine.
`default_nettype none
package ste_pkg;

   localparam int MAX_SIDE_DEFAULT = 16;
   localparam int QUEUE_DEPTH      = 2;

   localparam int CMD_W   = 2;
   localparam int IDX_W   = 4;
   localparam int SIDE_W  = 5;
   localparam int DIR_W   = 2;
   localparam int DATA_W  = 32;
   localparam int REQ_W   = 48;
   localparam int RSP_W   = 32;

   localparam logic [CMD_W-1:0] CMD_WRITE     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ      = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TRANSPOSE = 2'd2;

   localparam logic [DIR_W-1:0] DIR_MAIN = 2'b11;
   localparam logic [DIR_W-1:0] DIR_ANTI = 2'b01;

   localparam logic [SIDE_W-1:0] SIDE_RESET = 5'd16;

   typedef enum logic [2:0] {
      KIND_WRITE,
      KIND_READ,
      KIND_MAIN,
      KIND_ANTI,
      KIND_DONE,
      KIND_ERROR
   } kind_type;

   typedef struct packed {
      kind_type                kind;
      logic [IDX_W-1:0]        row;
      logic [IDX_W-1:0]        col;
      logic [DATA_W-1:0]       value;
      logic [SIDE_W-1:0]       sub_side;
   } desc_type;

endpackage
`default_nettype wire

/* rtl/core/ste_front.sv */
// Front end: side register, input decode and range checks into a job descriptor.
`default_nettype none
module ste_front #(
   parameter int MAX_SIDE = ste_pkg::MAX_SIDE_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [ste_pkg::SIDE_W-1:0]   csr_wr_data,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [ste_pkg::REQ_W-1:0]    req_tdata,
   input  wire logic [ste_pkg::CMD_W-1:0]    req_tuser,
   input  wire logic                         q_full,
   output logic                              q_wr_en,
   output ste_pkg::desc_type                 q_wr_data
);

   localparam logic [6:0] MAX_SIDE_W = 7'(MAX_SIDE);

   logic [ste_pkg::SIDE_W-1:0] matrix_side_ff;
   logic [ste_pkg::SIDE_W-1:0] matrix_side_in;

   logic [ste_pkg::IDX_W-1:0]  row;
   logic [ste_pkg::IDX_W-1:0]  col;
   logic [ste_pkg::DATA_W-1:0] value;
   logic [ste_pkg::DIR_W-1:0]  direction;
   logic [ste_pkg::SIDE_W-1:0] sub_side;
   logic [6:0]                 side;
   logic                       entry_ok;
   logic                       block_ok;

   assign matrix_side_in = csr_wr_en ? csr_wr_data : matrix_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_side_ff <= ste_pkg::SIDE_RESET;
      end else begin
         matrix_side_ff <= matrix_side_in;
      end
   end

   assign row       = req_tdata[3:0];
   assign col       = req_tdata[7:4];
   assign value     = req_tdata[39:8];
   assign direction = req_tdata[41:40];
   assign sub_side  = req_tdata[46:42];

   // A side register above the storage size acts as the storage size.
   assign side = (7'(matrix_side_ff) > MAX_SIDE_W) ? MAX_SIDE_W : 7'(matrix_side_ff);

   assign entry_ok = (7'(row) < side) && (7'(col) < side);
   assign block_ok = ((7'(row) + 7'(sub_side)) <= side) &&
                     ((7'(col) + 7'(sub_side)) <= side);

   assign req_tready = !q_full;
   assign q_wr_en    = req_tvalid && !q_full;

   always_comb begin
      q_wr_data.row      = row;
      q_wr_data.col      = col;
      q_wr_data.value    = value;
      q_wr_data.sub_side = sub_side;
      q_wr_data.kind     = ste_pkg::KIND_ERROR;
      unique case (req_tuser)
         ste_pkg::CMD_WRITE: begin
            if (entry_ok) q_wr_data.kind = ste_pkg::KIND_WRITE;
         end
         ste_pkg::CMD_READ: begin
            if (entry_ok) q_wr_data.kind = ste_pkg::KIND_READ;
         end
         ste_pkg::CMD_TRANSPOSE: begin
            // Blocks smaller than two entries on a side have nothing to swap.
            if (block_ok) begin
               if (sub_side < 5'd2) begin
                  q_wr_data.kind = ste_pkg::KIND_DONE;
               end else if (direction == ste_pkg::DIR_MAIN) begin
                  q_wr_data.kind = ste_pkg::KIND_MAIN;
               end else if (direction == ste_pkg::DIR_ANTI) begin
                  q_wr_data.kind = ste_pkg::KIND_ANTI;
               end else begin
                  q_wr_data.kind = ste_pkg::KIND_DONE;
               end
            end
         end
         default: q_wr_data.kind = ste_pkg::KIND_ERROR;
      endcase
   end

endmodule
`default_nettype wire

/* rtl/core/ste_queue.sv */
// Short descriptor queue between the front end and the execution unit.
`default_nettype none
module ste_queue (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         wr_en,
   input  wire ste_pkg::desc_type wr_data,
   output logic              full,
   input  wire logic         rd_en,
   output logic              not_empty,
   output ste_pkg::desc_type rd_data
);

   localparam int PTR_W = (ste_pkg::QUEUE_DEPTH > 1) ? $clog2(ste_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(ste_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(ste_pkg::QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(ste_pkg::QUEUE_DEPTH - 1);

   ste_pkg::desc_type slot_ff [ste_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push;
   logic              pop;

   assign full      = (count_ff == DEPTH_C);
   assign not_empty = (count_ff != '0);
   assign push      = wr_en && !full;
   assign pop       = rd_en && not_empty;
   assign rd_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_C) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_C) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= wr_data;
   end

endmodule
`default_nettype wire

/* rtl/core/ste_back.sv */
// Execution unit: matrix memory, swap sequencer and result register.
`default_nettype none
module ste_back #(
   parameter int MAX_SIDE = ste_pkg::MAX_SIDE_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         q_not_empty,
   input  wire ste_pkg::desc_type            q_rd_data,
   output logic                              q_rd_en,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic [ste_pkg::RSP_W-1:0]         rsp_tdata,
   output logic                              rsp_tuser
);

   localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FULL_W = ADDR_W + 6;
   localparam int SW     = ste_pkg::SIDE_W;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_SWAP  = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [SW-1:0] rr,
                                                   input logic [SW-1:0] cc);
      logic [FULL_W-1:0] k;
      k = FULL_W'(rr) * FULL_W'(MAX_SIDE) + FULL_W'(cc);
      return k[ADDR_W-1:0];
   endfunction

   logic [ste_pkg::DATA_W-1:0] mem [DEPTH];

   logic [1:0]                 state_ff, state_in;
   logic                       phase_ff, phase_in;
   logic                       pend_ff, pend_in;
   logic                       anti_ff;
   logic [SW-1:0]              row_ff, col_ff, side_ff;
   logic [SW-1:0]              i_ff, i_in, j_ff, j_in;
   logic [ADDR_W-1:0]          prev_a_ff, prev_b_ff;
   logic [ste_pkg::DATA_W-1:0] rdata_ff, da_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ste_pkg::DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                       rsp_err_ff, rsp_err_in;

   logic                       rsp_free;
   logic                       pop;
   logic                       rd_en;
   logic [ADDR_W-1:0]          rd_addr;
   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic [ste_pkg::DATA_W-1:0] wr_data;
   logic [ADDR_W-1:0]          addr_a, addr_b;
   logic [SW-1:0]              anti_lim;
   logic                       last_pair;
   logic                       set_rsp;

   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign pop      = (state_ff == ST_IDLE) && q_not_empty && rsp_free;
   assign q_rd_en  = pop;

   // Main diagonal pairs (i,j) with (j,i); anti-diagonal pairs (i,j) with
   // (s-1-j, s-1-i). Pairs never overlap, so the order of swaps is free.
   assign addr_a = cell_addr(row_ff + i_ff, col_ff + j_ff);
   assign addr_b = anti_ff ?
                   cell_addr(row_ff + side_ff - 5'd1 - j_ff, col_ff + side_ff - 5'd1 - i_ff) :
                   cell_addr(row_ff + j_ff, col_ff + i_ff);

   assign anti_lim  = side_ff - 5'd1 - i_ff;
   assign last_pair = anti_ff ? ((i_ff + 5'd2) == side_ff) :
                                ((j_ff + 5'd1) == i_ff) && ((i_ff + 5'd1) == side_ff);

   // Each pair is read in two phases: read A then read B. The writes of the
   // previous pair ride along in the same two phases on the write port.
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      pend_in      = pend_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      rd_en        = 1'b0;
      rd_addr      = addr_a;
      wr_en        = 1'b0;
      wr_addr      = prev_a_ff;
      wr_data      = rdata_ff;
      set_rsp      = 1'b0;
      rsp_data_in  = '0;
      rsp_err_in   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               case (q_rd_data.kind)
                  ste_pkg::KIND_WRITE: begin
                     wr_en   = 1'b1;
                     wr_addr = cell_addr(SW'(q_rd_data.row), SW'(q_rd_data.col));
                     wr_data = q_rd_data.value;
                     set_rsp = 1'b1;
                  end
                  ste_pkg::KIND_READ: begin
                     rd_en    = 1'b1;
                     rd_addr  = cell_addr(SW'(q_rd_data.row), SW'(q_rd_data.col));
                     state_in = ST_READ;
                  end
                  ste_pkg::KIND_MAIN: begin
                     i_in     = 5'd1;
                     j_in     = '0;
                     phase_in = 1'b0;
                     pend_in  = 1'b0;
                     state_in = ST_SWAP;
                  end
                  ste_pkg::KIND_ANTI: begin
                     i_in     = '0;
                     j_in     = '0;
                     phase_in = 1'b0;
                     pend_in  = 1'b0;
                     state_in = ST_SWAP;
                  end
                  ste_pkg::KIND_DONE: begin
                     set_rsp = 1'b1;
                  end
                  default: begin
                     set_rsp    = 1'b1;
                     rsp_err_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            set_rsp     = 1'b1;
            rsp_data_in = rdata_ff;
            state_in    = ST_IDLE;
         end
         ST_SWAP: begin
            rd_en = 1'b1;
            if (!phase_ff) begin
               rd_addr = addr_a;
               wr_en   = pend_ff;
               wr_addr = prev_a_ff;
               wr_data = rdata_ff;
               phase_in = 1'b1;
            end else begin
               rd_addr  = addr_b;
               wr_en    = pend_ff;
               wr_addr  = prev_b_ff;
               wr_data  = da_ff;
               pend_in  = 1'b1;
               phase_in = 1'b0;
               if (last_pair) begin
                  state_in = ST_DRAIN;
               end else if (anti_ff) begin
                  if ((j_ff + 5'd1) == anti_lim) begin
                     i_in = i_ff + 5'd1;
                     j_in = '0;
                  end else begin
                     j_in = j_ff + 5'd1;
                  end
               end else begin
                  if ((j_ff + 5'd1) == i_ff) begin
                     i_in = i_ff + 5'd1;
                     j_in = '0;
                  end else begin
                     j_in = j_ff + 5'd1;
                  end
               end
            end
         end
         ST_DRAIN: begin
            wr_en = 1'b1;
            if (!phase_ff) begin
               wr_addr  = prev_a_ff;
               wr_data  = rdata_ff;
               phase_in = 1'b1;
            end else begin
               wr_addr  = prev_b_ff;
               wr_data  = da_ff;
               phase_in = 1'b0;
               pend_in  = 1'b0;
               set_rsp  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = set_rsp ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      if (pop) begin
         row_ff  <= SW'(q_rd_data.row);
         col_ff  <= SW'(q_rd_data.col);
         side_ff <= q_rd_data.sub_side;
         anti_ff <= (q_rd_data.kind == ste_pkg::KIND_ANTI);
      end
      if (state_ff == ST_SWAP && phase_ff) begin
         prev_a_ff <= addr_a;
         prev_b_ff <= addr_b;
         da_ff     <= rdata_ff;
      end
      if (set_rsp) begin
         rsp_data_ff <= rsp_data_in;
         rsp_err_ff  <= rsp_err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rdata_ff <= mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule
`default_nettype wire

/* rtl/core/submatrix_transpose_engine.sv */
// Top level of the submatrix transpose engine: front end, queue and execution unit.
//
// The block keeps a MAX_SIDE x MAX_SIDE matrix of signed 32-bit entries and
// serves commands on the req_ stream: write an entry, read an entry, or
// transpose a square block in place about its main or anti-diagonal.
// Every transfer on req_ yields exactly one transfer on rsp_, in order,
// carrying the read value (zero unless a read succeeded) and an error flag.
// The csr_ port writes the side of the matrix in use; write it only while
// no command is in flight.
// A command is checked on acceptance and waits in a two-entry queue. The
// execution unit works on one command at a time through a single memory
// with one write and one registered read port: a write, a rejected command
// or a transpose with nothing to swap sets the result as it leaves the queue,
// a read passes through the read state, and a swapping transpose reads each
// pair in two phases, writes it back while the next pair is read and writes
// the last pair in a drain state. rsp_tvalid comes from the result register,
// which a read reaches through the registered read port. Reset empties the
// queue and the result register and sets the side to 16; the matrix contents
// stay undefined until written. While rsp_tready is low the result holds, the
// next command is not started, and req_tready drops once the queue is full.
`default_nettype none
module submatrix_transpose_engine #(
   parameter int MAX_SIDE = ste_pkg::MAX_SIDE_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [ste_pkg::SIDE_W-1:0]  csr_wr_data,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // row[3:0], col[7:4], value[39:8], direction[41:40], sub_side[46:42]
   input  wire logic [ste_pkg::REQ_W-1:0]   req_tdata,
   // command[1:0]
   input  wire logic [ste_pkg::CMD_W-1:0]   req_tuser,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // read_value[31:0]
   output logic [ste_pkg::RSP_W-1:0]        rsp_tdata,
   // status[0]
   output logic                             rsp_tuser
);

   logic              q_full;
   logic              q_wr_en;
   ste_pkg::desc_type q_wr_data;
   logic              q_rd_en;
   logic              q_not_empty;
   ste_pkg::desc_type q_rd_data;

   ste_front #(
      .MAX_SIDE (MAX_SIDE)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .q_full      (q_full),
      .q_wr_en     (q_wr_en),
      .q_wr_data   (q_wr_data)
   );

   ste_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (q_wr_en),
      .wr_data   (q_wr_data),
      .full      (q_full),
      .rd_en     (q_rd_en),
      .not_empty (q_not_empty),
      .rd_data   (q_rd_data)
   );

   ste_back #(
      .MAX_SIDE (MAX_SIDE)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_rd_data   (q_rd_data),
      .q_rd_en     (q_rd_en),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

endmodule
`default_nettype wire

/* tb/sv/tb_submatrix_transpose_engine.sv */
// Self-checking testbench for the submatrix transpose engine with its own matrix predictor.
`timescale 1ns / 100ps
module tb_submatrix_transpose_engine;

   localparam int SIDE_MAX = ste_pkg::MAX_SIDE_DEFAULT;
   localparam int CELLS    = SIDE_MAX * SIDE_MAX;

   localparam logic [ste_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam logic [ste_pkg::DIR_W-1:0] DIR_NONE   = 2'b00;
   localparam logic [ste_pkg::DIR_W-1:0] DIR_ODD    = 2'b10;

   // Field order matches {req_tuser, req_tdata[46:0]}.
   typedef struct packed {
      logic [ste_pkg::CMD_W-1:0]  cmd;
      logic [ste_pkg::SIDE_W-1:0] sub_side;
      logic [ste_pkg::DIR_W-1:0]  dir;
      logic [ste_pkg::DATA_W-1:0] value;
      logic [ste_pkg::IDX_W-1:0]  col;
      logic [ste_pkg::IDX_W-1:0]  row;
   } req_item_type;

   typedef struct packed {
      logic [ste_pkg::DATA_W-1:0] read_value;
      logic                       status;
   } reply_type;

   logic                         clock       = 1'b0;
   logic                         reset       = 1'b1;
   logic                         csr_wr_en   = 1'b0;
   logic [ste_pkg::SIDE_W-1:0]   csr_wr_data = '0;
   logic                         req_tvalid  = 1'b0;
   logic                         req_tready;
   logic [ste_pkg::REQ_W-1:0]    req_tdata   = '0;
   logic [ste_pkg::CMD_W-1:0]    req_tuser   = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready  = 1'b0;
   logic [ste_pkg::RSP_W-1:0]    rsp_tdata;
   logic                         rsp_tuser;

   submatrix_transpose_engine dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always #2 clock = ~clock;

   req_item_type pending_cmds[$];
   reply_type    expected_replies[$];
   int           cmds_issued    = 0;
   int           replies_seen   = 0;
   int           fail_count     = 0;
   int           send_idle_pct  = 0;
   int           stall_pct      = 0;
   logic         req_taken      = 1'b0;
   req_item_type next_req;
   req_item_type seen_req;
   reply_type    got_reply;
   reply_type    want_reply;

   // Predictor state, updated on accepted transfers and register writes.
   logic [ste_pkg::DATA_W-1:0] shadow_matrix [CELLS];
   logic [ste_pkg::DATA_W-1:0] cell_scratch  [CELLS];
   int                         shadow_side = ste_pkg::SIDE_RESET;

   // Stimulus-side view: which cells hold a written value, so that no read
   // ever lands on contents that are undefined.
   bit stim_written [CELLS];
   bit flag_scratch [CELLS];
   int stim_side = ste_pkg::SIDE_RESET;

   function automatic bit range_fault(req_item_type it, int side);
      int eff, r, c, s;
      eff = side > SIDE_MAX ? SIDE_MAX : side;
      r = int'(it.row);
      c = int'(it.col);
      s = int'(it.sub_side);
      case (it.cmd) inside
         ste_pkg::CMD_WRITE, ste_pkg::CMD_READ: return r >= eff || c >= eff;
         ste_pkg::CMD_TRANSPOSE:                return r + s > eff || c + s > eff;
         default:                               return 1'b1;
      endcase
   endfunction

   // A mirror is an involution, so each cell simply takes the value of its
   // mirror partner; cells outside the block are their own partner.
   function automatic int mirror_source(int k, req_item_type it);
      int rr, cc, r, c, s, i, j;
      rr = k / SIDE_MAX;
      cc = k % SIDE_MAX;
      r = int'(it.row);
      c = int'(it.col);
      s = int'(it.sub_side);
      if (rr < r || cc < c || rr >= r + s || cc >= c + s) return k;
      i = rr - r;
      j = cc - c;
      if (it.dir == ste_pkg::DIR_MAIN) return (r + j) * SIDE_MAX + (c + i);
      if (it.dir == ste_pkg::DIR_ANTI) return (r + s - 1 - j) * SIDE_MAX + (c + s - 1 - i);
      return k;
   endfunction

   function automatic int cell_index(req_item_type it);
      return int'(it.row) * SIDE_MAX + int'(it.col);
   endfunction

   function void predict_reply(req_item_type it);
      reply_type rep;
      rep = '0;
      if (range_fault(it, shadow_side)) begin
         rep.status = 1'b1;
      end else begin
         case (it.cmd)
            ste_pkg::CMD_WRITE: shadow_matrix[cell_index(it)] = it.value;
            ste_pkg::CMD_READ:  rep.read_value = shadow_matrix[cell_index(it)];
            default: begin
               for (int k = 0; k < CELLS; k++) cell_scratch[k] = shadow_matrix[k];
               for (int k = 0; k < CELLS; k++)
                  shadow_matrix[k] = cell_scratch[mirror_source(k, it)];
            end
         endcase
      end
      expected_replies = {expected_replies, rep};
   endfunction

   task automatic queue_item(req_item_type it);
      if (!range_fault(it, stim_side)) begin
         if (it.cmd == ste_pkg::CMD_WRITE) begin
            stim_written[cell_index(it)] = 1'b1;
         end else if (it.cmd == ste_pkg::CMD_TRANSPOSE) begin
            for (int k = 0; k < CELLS; k++) flag_scratch[k] = stim_written[k];
            for (int k = 0; k < CELLS; k++)
               stim_written[k] = flag_scratch[mirror_source(k, it)];
         end
      end
      pending_cmds = {pending_cmds, it};
      cmds_issued++;
   endtask

   function automatic req_item_type make_item(logic [ste_pkg::CMD_W-1:0] cmd, int row,
                                              int col, logic [ste_pkg::DATA_W-1:0] value,
                                              logic [ste_pkg::DIR_W-1:0] dir, int sub_side);
      req_item_type it;
      it.cmd      = cmd;
      it.row      = ste_pkg::IDX_W'(row);
      it.col      = ste_pkg::IDX_W'(col);
      it.value    = value;
      it.dir      = dir;
      it.sub_side = ste_pkg::SIDE_W'(sub_side);
      return it;
   endfunction

   function automatic req_item_type random_item();
      req_item_type it;
      int eff, pick, s, k;
      int cands[$];
      eff = stim_side > SIDE_MAX ? SIDE_MAX : stim_side;
      it.cmd      = CMD_UNUSED;
      it.row      = ste_pkg::IDX_W'($urandom_range(SIDE_MAX - 1));
      it.col      = ste_pkg::IDX_W'($urandom_range(SIDE_MAX - 1));
      it.value    = $urandom;
      it.dir      = ste_pkg::DIR_W'($urandom_range(3));
      it.sub_side = ste_pkg::SIDE_W'($urandom_range(31));
      if ($urandom_range(9) == 0) begin
         case ($urandom_range(3))
            0:       it.value = 32'h8000_0000;
            1:       it.value = 32'h7FFF_FFFF;
            2:       it.value = 32'hFFFF_FFFF;
            default: it.value = '0;
         endcase
      end
      pick = $urandom_range(99);
      if (pick >= 5 && pick < 70) begin
         it.cmd = pick < 38 ? ste_pkg::CMD_WRITE : ste_pkg::CMD_READ;
         if (eff > 0 && $urandom_range(9) != 0) begin
            it.row = ste_pkg::IDX_W'($urandom_range(eff - 1));
            it.col = ste_pkg::IDX_W'($urandom_range(eff - 1));
         end
         if (it.cmd == ste_pkg::CMD_READ && !range_fault(it, stim_side)
             && !stim_written[cell_index(it)]) begin
            for (k = 0; k < CELLS; k++)
               if (stim_written[k] && k / SIDE_MAX < eff && k % SIDE_MAX < eff)
                  cands = {cands, k};
            if (cands.size() == 0) begin
               it.cmd = ste_pkg::CMD_WRITE;
            end else begin
               k = cands[$urandom_range(cands.size() - 1)];
               it.row = ste_pkg::IDX_W'(k / SIDE_MAX);
               it.col = ste_pkg::IDX_W'(k % SIDE_MAX);
            end
         end
      end else if (pick >= 70) begin
         it.cmd = ste_pkg::CMD_TRANSPOSE;
         pick = $urandom_range(99);
         if (pick < 45)      it.dir = ste_pkg::DIR_MAIN;
         else if (pick < 90) it.dir = ste_pkg::DIR_ANTI;
         else if (pick < 95) it.dir = DIR_NONE;
         else                it.dir = DIR_ODD;
         // Most transposes are well formed and small; the rest keep random fields.
         if ($urandom_range(99) < 85) begin
            if (eff == 0) begin
               s = 0;
               it.row = '0;
               it.col = '0;
            end else begin
               s = $urandom_range(4) != 0 ? $urandom_range(eff < 5 ? eff : 5)
                                          : $urandom_range(eff);
               it.row = ste_pkg::IDX_W'($urandom_range(eff - s));
               it.col = ste_pkg::IDX_W'($urandom_range(eff - s));
            end
            it.sub_side = ste_pkg::SIDE_W'(s);
         end
      end
      return it;
   endfunction

   task automatic write_side(int v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ste_pkg::SIDE_W'(v);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      stim_side = v;
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (replies_seen < cmds_issued);
      repeat (16) @(negedge clock);
   endtask

   task automatic run_phase(int side, int sender_idle, int receiver_stall, int count);
      write_side(side);
      send_idle_pct = sender_idle;
      stall_pct     = receiver_stall;
      repeat (count) queue_item(random_item());
      wait_drained();
   endtask

   // Request driver: a new transfer is offered once the previous one was taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_req = pending_cmds.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {1'b0, next_req[46:0]};
            req_tuser  <= next_req.cmd;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= stall_pct);
   end

   // Monitor: updates the predictor on accepted transfers and checks replies.
   always @(posedge clock) begin
      req_taken <= req_tvalid && req_tready;
      if (!reset) begin
         if (csr_wr_en) shadow_side = int'(csr_wr_data);
         if (req_tvalid && req_tready) begin
            seen_req = {req_tuser, req_tdata[46:0]};
            predict_reply(seen_req);
         end
         if (rsp_tvalid && rsp_tready) begin
            replies_seen++;
            got_reply.read_value = rsp_tdata;
            got_reply.status     = rsp_tuser;
            if (expected_replies.size() == 0) begin
               $error("reply transfer with no command outstanding: read_value %h status %0d",
                      got_reply.read_value, got_reply.status);
               fail_count++;
            end else begin
               want_reply = expected_replies.pop_front();
               if (got_reply.read_value !== want_reply.read_value) begin
                  $error("read_value mismatch: expected %h, actual %h",
                         want_reply.read_value, got_reply.read_value);
                  fail_count++;
               end
               if (got_reply.status !== want_reply.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want_reply.status, got_reply.status);
                  fail_count++;
               end
            end
         end
      end
   end

   initial begin
      for (int k = 0; k < CELLS; k++) begin
         shadow_matrix[k] = '0;
         stim_written[k]  = 1'b0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part at the reset side of 16.
      queue_item(make_item(ste_pkg::CMD_WRITE, 0, 0, 32'h8000_0000, DIR_NONE, 0));
      queue_item(make_item(ste_pkg::CMD_WRITE, 15, 15, 32'h7FFF_FFFF, DIR_NONE, 0));
      queue_item(make_item(ste_pkg::CMD_WRITE, 0, 15, 32'hFFFF_FFFF, DIR_NONE, 0));
      queue_item(make_item(ste_pkg::CMD_WRITE, 15, 0, 32'h0, DIR_NONE, 0));
      queue_item(make_item(ste_pkg::CMD_WRITE, 1, 0, 32'd5, DIR_NONE, 0));
      queue_item(make_item(ste_pkg::CMD_WRITE, 0, 1, 32'd6, DIR_NONE, 0));
      queue_item(make_item(ste_pkg::CMD_READ, 0, 0, 32'h0, DIR_NONE, 0));
      queue_item(make_item(ste_pkg::CMD_READ, 15, 15, 32'h0, DIR_NONE, 0));
      queue_item(make_item(ste_pkg::CMD_READ, 1, 0, 32'h0, DIR_NONE, 0));
      queue_item(make_item(ste_pkg::CMD_TRANSPOSE, 0, 0, 32'h0, ste_pkg::DIR_MAIN, 16));
      queue_item(make_item(ste_pkg::CMD_READ, 0, 15, 32'h0, DIR_NONE, 0));
      queue_item(make_item(ste_pkg::CMD_READ, 0, 1, 32'h0, DIR_NONE, 0));
      queue_item(make_item(ste_pkg::CMD_TRANSPOSE, 0, 0, 32'h0, ste_pkg::DIR_ANTI, 16));
      queue_item(make_item(ste_pkg::CMD_READ, 15, 15, 32'h0, DIR_NONE, 0));
      queue_item(make_item(ste_pkg::CMD_READ, 15, 14, 32'h0, DIR_NONE, 0));
      queue_item(make_item(ste_pkg::CMD_TRANSPOSE, 14, 14, 32'h0, ste_pkg::DIR_MAIN, 2));
      queue_item(make_item(ste_pkg::CMD_READ, 14, 15, 32'h0, DIR_NONE, 0));
      // Direction zero and the odd pattern leave the block as it is.
      queue_item(make_item(ste_pkg::CMD_TRANSPOSE, 1, 1, 32'h0, DIR_NONE, 3));
      queue_item(make_item(ste_pkg::CMD_TRANSPOSE, 1, 1, 32'h0, DIR_ODD, 3));
      // An empty block in the far corner still fits.
      queue_item(make_item(ste_pkg::CMD_TRANSPOSE, 15, 15, 32'h0, ste_pkg::DIR_MAIN, 0));
      queue_item(make_item(ste_pkg::CMD_TRANSPOSE, 10, 10, 32'h0, ste_pkg::DIR_MAIN, 7));
      queue_item(make_item(ste_pkg::CMD_TRANSPOSE, 0, 0, 32'h0, ste_pkg::DIR_ANTI, 31));
      queue_item(make_item(CMD_UNUSED, 3, 4, 32'hA5A5_5A5A, ste_pkg::DIR_ANTI, 9));
      queue_item(make_item(ste_pkg::CMD_WRITE, 15, 15, 32'h1234_5678, DIR_ODD, 31));
      wait_drained();

      run_phase(16, 0, 0, 300);
      run_phase(5, 76, 0, 200);
      run_phase(0, 0, 76, 60);
      run_phase(31, 34, 34, 250);
      run_phase(1, 0, 0, 80);
      run_phase(12, 0, 76, 200);
      run_phase(17, 76, 0, 150);
      run_phase(16, 34, 34, 210);

      if (expected_replies.size() != 0) begin
         $error("%0d expected replies never arrived", expected_replies.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #12_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
